// ===== hw/rtl/ils_pkg.sv =====
// Shared types and constants for the indexed list store.
// Holds the request and response structs, command codes, controller states
// and the command and status structs between controller and datapath.
`default_nettype none

package ils_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = 8;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int COUNT_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] CMD_READ = 3'd0;
	localparam logic [2:0] CMD_INS_HEAD = 3'd1;
	localparam logic [2:0] CMD_INS_TAIL = 3'd2;
	localparam logic [2:0] CMD_INS_AT = 3'd3;
	localparam logic [2:0] CMD_DELETE = 3'd4;

	typedef struct packed {
		logic [2:0] cmd;
		logic [POS_W-1:0] position;
		logic signed [DATA_W-1:0] value;
	} ils_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic found;
		logic refused;
		logic [COUNT_W-1:0] count;
	} ils_rsp_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_READ,
		OP_INSERT,
		OP_DELETE
	} ils_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ils_state_t;

	typedef struct packed {
		logic load;
		logic exec;
		ils_op_t op;
		logic [IDX_W-1:0] at;
		logic found;
		logic refused;
	} ils_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0] fill;
		logic [2:0] cmd;
		logic [POS_W-1:0] position;
	} ils_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ils_ctrl.sv =====
// Controller for the indexed list store: a two-state machine that takes a request
// and decides the operation, target index and flags. Depends on ils_pkg.
`default_nettype none

module ils_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire ils_pkg::ils_status_t status,
	output ils_pkg::ils_ctl_t ctl
);
	import ils_pkg::*;

	ils_state_t state_q;
	ils_state_t state_nxt;
	logic full;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] fill_x;

	assign full = (status.fill == CNT_W'(CAPACITY));
	assign pos_x = CMP_W'(status.position);
	assign fill_x = CMP_W'(status.fill);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.op = OP_NONE;
		busy = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ctl.load = start;
			end
			ST_EXEC: begin
				busy = 1'b1;
				ctl.exec = 1'b1;
				case (status.cmd)
					CMD_READ: begin
						ctl.op = OP_READ;
						ctl.at = IDX_W'(status.position);
						if (pos_x < fill_x) begin
							ctl.found = 1'b1;
						end else begin
							ctl.refused = 1'b1;
						end
					end
					CMD_INS_HEAD: begin
						if (full) begin
							ctl.refused = 1'b1;
						end else begin
							ctl.op = OP_INSERT;
						end
					end
					CMD_INS_TAIL: begin
						if (full) begin
							ctl.refused = 1'b1;
						end else begin
							ctl.op = OP_INSERT;
							ctl.at = IDX_W'(status.fill);
						end
					end
					CMD_INS_AT: begin
						if (full || pos_x > fill_x) begin
							ctl.refused = 1'b1;
						end else begin
							ctl.op = OP_INSERT;
							ctl.at = IDX_W'(status.position);
						end
					end
					CMD_DELETE: begin
						if (pos_x >= fill_x) begin
							ctl.refused = 1'b1;
						end else begin
							ctl.op = OP_DELETE;
							ctl.at = IDX_W'(status.position);
						end
					end
					default: begin
						ctl.refused = 1'b1;
					end
				endcase
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ils_dpath.sv =====
// Datapath for the indexed list store: the request register, a chain of entry
// cells that all shift up or down at once, the fill count and the response.
// Depends on ils_pkg.
`default_nettype none

module ils_dpath (
	input wire logic clk,
	input wire logic arst_n,
	input wire ils_pkg::ils_req_t req,
	input wire ils_pkg::ils_ctl_t ctl,
	output ils_pkg::ils_status_t status,
	output logic done,
	output ils_pkg::ils_rsp_t rsp
);
	import ils_pkg::*;

	ils_req_t req_q;
	logic signed [DATA_W-1:0] entry_q [CAPACITY];
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_nxt;
	logic done_q;
	ils_rsp_t rsp_q;
	logic signed [DATA_W-1:0] rd_data;

	assign status.fill = fill_q;
	assign status.cmd = req_q.cmd;
	assign status.position = req_q.position;
	assign done = done_q;
	assign rsp = rsp_q;

	always_comb begin
		rd_data = entry_q[ctl.at];
		fill_nxt = fill_q;
		case (ctl.op)
			OP_INSERT: fill_nxt = fill_q + CNT_W'(1);
			OP_DELETE: fill_nxt = fill_q - CNT_W'(1);
			default: fill_nxt = fill_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (ctl.op == OP_INSERT) begin
					if (IDX_W'(i) == ctl.at) begin
						entry_q[i] <= req_q.value;
					end else if (i > 0 && IDX_W'(i) > ctl.at) begin
						entry_q[i] <= entry_q[(i > 0) ? i - 1 : 0];
					end
				end else if (ctl.op == OP_DELETE) begin
					if (i < CAPACITY - 1 && IDX_W'(i) >= ctl.at) begin
						entry_q[i] <= entry_q[(i < CAPACITY - 1) ? i + 1 : i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.exec;
			if (ctl.exec) begin
				fill_q <= fill_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			if (ctl.op == OP_READ) begin
				rsp_q.read_value <= ctl.found ? rd_data : -DATA_W'(1);
			end else begin
				rsp_q.read_value <= '0;
			end
			rsp_q.found <= ctl.found;
			rsp_q.refused <= ctl.refused;
			rsp_q.count <= COUNT_W'(fill_nxt);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_list_store.sv =====
// Top level of the indexed list store: joins the controller and the datapath.
// Depends on ils_pkg, ils_ctrl and ils_dpath.
//
// A request is accepted when start is high and busy is low; the entry cells
// shift and the response is formed in the next cycle, and done then marks the
// response on rsp for exactly one cycle, while a new request may already be
// accepted. The receiver cannot stall, so every response must be taken in the
// cycle in which done is high. Entries are held in a chain of registers that
// moves every entry at once, and the state machine handles one request at a
// time: no new request is accepted while busy is high. No clearing pass is
// needed after reset.
`default_nettype none

module indexed_list_store (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire ils_pkg::ils_req_t req,
	output logic done,
	output ils_pkg::ils_rsp_t rsp
);
	import ils_pkg::*;

	ils_ctl_t ctl;
	ils_status_t status;

	ils_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.status(status),
		.ctl(ctl)
	);

	ils_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.ctl(ctl),
		.status(status),
		.done(done),
		.rsp(rsp)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("Accepted request did not make the block busy.");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("Busy cycle was not followed by a response.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.count <= COUNT_W'(CAPACITY))
		else $error("Entry count exceeds capacity.");

	a_found_not_refused: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.found && rsp.refused))
		else $error("Response is both found and refused.");
`endif

endmodule

`default_nettype wire
